[rtl/frame_deadline_pacer_unit_macros.svh]
// Assertion macros shared by the frame deadline pacer RTL.
// Needs clk and rst_n in the scope of each use; no other dependencies.
`ifndef FRAME_DEADLINE_PACER_UNIT_MACROS_SVH
`define FRAME_DEADLINE_PACER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define FDP_ASSERT_IMP(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define FDP_ASSERT_NEXT(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`else

`define FDP_ASSERT_IMP(name, cond, expr, msg)
`define FDP_ASSERT_NEXT(name, cond, expr, msg)

`endif

`endif

[rtl/fdp_pkg.sv]
// Types, widths and codes shared by the frame deadline pacer modules.
// No dependencies.
package fdp_pkg;

    // Field widths
    localparam int NOW_W     = 63;
    localparam int RATE_W    = 16;
    localparam int DEBT_W    = 30;
    localparam int SPIN_W    = 24;
    localparam int PERIOD_W  = 30;
    localparam int CNT_W     = 32;
    localparam int ACT_W     = 3;
    localparam int LIMIT_W   = 31;
    localparam int SPINWIN_W = PERIOD_W - 3;

    // Shared serial divider
    localparam int DIV_W     = 30;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Register port
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 3;

    localparam logic [PERIOD_W-1:0] NS_PER_SEC = 30'd1_000_000_000;
    localparam logic [RATE_W-1:0]   RATE_RST   = 16'd60;
    localparam logic [DEBT_W-1:0]   DEBT_RST   = 30'd250_000_000;
    localparam logic [SPIN_W-1:0]   SPIN_RST   = 24'd500_000;

    typedef enum logic [IDX_W-1:0] {
        REG_ENABLE = 3'd0,
        REG_RATE   = 3'd1,
        REG_POLICY = 3'd2,
        REG_DEBT   = 3'd3,
        REG_SPIN   = 3'd4
    } reg_idx_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_DISABLED = 3'd0,
        ACT_STARTED  = 3'd1,
        ACT_WAIT     = 3'd2,
        ACT_CARRY    = 3'd3,
        ACT_RESYNC   = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_RATE,
        ST_CMP,
        ST_LIMIT,
        ST_DIV_DEBT,
        ST_RESOLVE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                enable;
        logic [RATE_W-1:0]   rate;
        logic                policy;
        logic [DEBT_W-1:0]   debt;
        logic [SPIN_W-1:0]   spin;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic start;
        logic div_go;
        logic div_debt;
        logic add_period;
        logic compare;
        logic set_limit;
        logic resolve;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic enabled;
        logic started;
        logic div_busy;
        logic miss;
        logic need_div;
        logic out_busy;
    } dp_sts_t;

endpackage

[rtl/fdp_regs.sv]
// APB-style configuration registers of the frame deadline pacer.
// Depends on fdp_pkg.
module fdp_regs (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [fdp_pkg::ADDR_W-1:0] paddr,
    input  logic [fdp_pkg::DATA_W-1:0] pwdata,
    output logic [fdp_pkg::DATA_W-1:0] prdata,
    output logic                   pready,
    output fdp_pkg::cfg_t          cfg,
    output logic                   cfg_clear
);
    import fdp_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_en;
    logic     idx_ok;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    // Decode of defined register slots
    always_comb
    begin
        unique case (idx)
            REG_ENABLE, REG_RATE, REG_POLICY, REG_DEBT, REG_SPIN: idx_ok = 1'b1;
            default: idx_ok = 1'b0;
        endcase
    end

    // Any defined write restarts the deadline
    assign cfg_clear = wr_en && idx_ok;
    assign cfg       = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable <= 1'b0;
            cfg_reg.rate   <= RATE_RST;
            cfg_reg.policy <= 1'b0;
            cfg_reg.debt   <= DEBT_RST;
            cfg_reg.spin   <= SPIN_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ENABLE: cfg_reg.enable <= pwdata[0];
                REG_RATE:   cfg_reg.rate   <= pwdata[RATE_W-1:0];
                REG_POLICY: cfg_reg.policy <= pwdata[0];
                REG_DEBT:   cfg_reg.debt   <= pwdata[DEBT_W-1:0];
                REG_SPIN:   cfg_reg.spin   <= pwdata[SPIN_W-1:0];
                default:    ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_ENABLE: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.enable};
            REG_RATE:   prdata = {{(DATA_W-RATE_W){1'b0}}, cfg_reg.rate};
            REG_POLICY: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.policy};
            REG_DEBT:   prdata = {{(DATA_W-DEBT_W){1'b0}}, cfg_reg.debt};
            REG_SPIN:   prdata = {{(DATA_W-SPIN_W){1'b0}}, cfg_reg.spin};
            default:    prdata = '0;
        endcase
    end

endmodule

[rtl/fdp_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on fdp_pkg and the assertion macro header.
`include "frame_deadline_pacer_unit_macros.svh"

module fdp_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic [fdp_pkg::DIV_W-1:0] dividend,
    input  logic [fdp_pkg::DIV_W-1:0] divisor,
    output logic                      busy,
    output logic [fdp_pkg::DIV_W-1:0] quotient,
    output logic [fdp_pkg::DIV_W-1:0] remainder
);
    import fdp_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     q_reg;
    logic [DIV_W-1:0]     r_reg;
    logic [DIV_W-1:0]     d_reg;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       trial_diff;
    logic                 fits;
    logic [DIV_W-1:0]     q_next;
    logic [DIV_W-1:0]     r_next;

    // One shift-subtract step
    always_comb
    begin
        trial      = {r_reg, q_reg[DIV_W-1]};
        trial_diff = trial - {1'b0, d_reg};
        fits       = (trial >= {1'b0, d_reg});
        r_next     = fits ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
        q_next     = {q_reg[DIV_W-2:0], fits};
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

    `FDP_ASSERT_NEXT(a_div_go_busy, go, busy_reg, "divider did not start")
    `FDP_ASSERT_IMP(a_div_rem_bound, $fell(busy_reg), r_reg < d_reg, "remainder not below divisor")

endmodule

[rtl/fdp_dp.sv]
// Datapath of the frame deadline pacer: deadline state, counters, result word.
// Depends on fdp_pkg, fdp_div and the assertion macro header.
`include "frame_deadline_pacer_unit_macros.svh"

module fdp_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fdp_pkg::dp_cmd_t             cmd,
    output fdp_pkg::dp_sts_t             sts,
    input  fdp_pkg::cfg_t                cfg,
    input  logic                         cfg_clear,
    input  logic [fdp_pkg::NOW_W-1:0]    now_ns,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fdp_pkg::ACT_W-1:0]    action,
    output logic [fdp_pkg::NOW_W-1:0]    deadline_ns,
    output logic [fdp_pkg::NOW_W-1:0]    sleep_until_ns,
    output logic [fdp_pkg::NOW_W-1:0]    lateness_ns,
    output logic [fdp_pkg::PERIOD_W-1:0] period_ns,
    output logic [fdp_pkg::CNT_W-1:0]    miss_count,
    output logic [fdp_pkg::CNT_W-1:0]    resync_count
);
    import fdp_pkg::*;

    // Pacing state
    logic                started_reg;
    logic [NOW_W-1:0]    nd_reg;
    logic [RATE_W-1:0]   rem_reg;
    logic [CNT_W-1:0]    misses_reg;
    logic [CNT_W-1:0]    resyncs_reg;

    // Per-word working registers
    logic [NOW_W-1:0]    now_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [NOW_W-1:0]    late_reg;
    logic [NOW_W-1:0]    sleep_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic                miss_reg;
    action_t             act_reg;

    // Result word
    logic                out_valid_reg;
    logic [ACT_W-1:0]    out_act_reg;
    logic [NOW_W-1:0]    out_deadline_reg;
    logic [NOW_W-1:0]    out_sleep_reg;
    logic [NOW_W-1:0]    out_late_reg;
    logic [PERIOD_W-1:0] out_period_reg;
    logic [CNT_W-1:0]    out_miss_reg;
    logic [CNT_W-1:0]    out_resync_reg;

    logic [DIV_W-1:0]     div_dividend;
    logic [DIV_W-1:0]     div_divisor;
    logic                 div_busy;
    logic [DIV_W-1:0]     div_quot;
    logic [DIV_W-1:0]     div_rem;
    logic [NOW_W:0]       cmp_diff;
    logic                 now_ge;
    logic [SPINWIN_W-1:0] spin_cfg;
    logic [SPINWIN_W-1:0] spin_per8;
    logic [SPINWIN_W-1:0] spin_win;
    logic [NOW_W:0]       sleep_diff;
    logic [NOW_W-1:0]     sleep_next;
    logic [LIMIT_W-1:0]   limit_next;
    logic                 carry;

    // Divider operand select: rate step or debt rounding
    assign div_dividend = cmd.div_debt ? cfg.debt : (PERIOD_W'(rem_reg) + NS_PER_SEC);
    assign div_divisor  = cmd.div_debt ? period_reg : {{(DIV_W-RATE_W){1'b0}}, cfg.rate};

    fdp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (cmd.div_go),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Miss test and sleep point
    always_comb
    begin
        cmp_diff   = {1'b0, now_reg} - {1'b0, nd_reg};
        now_ge     = !cmp_diff[NOW_W];
        spin_cfg   = {{(SPINWIN_W-SPIN_W){1'b0}}, cfg.spin};
        spin_per8  = period_reg[PERIOD_W-1:3];
        spin_win   = (spin_cfg < spin_per8) ? spin_cfg : spin_per8;
        sleep_diff = {1'b0, nd_reg} - {{(NOW_W+1-SPINWIN_W){1'b0}}, spin_win};
        sleep_next = sleep_diff[NOW_W] ? '0 : sleep_diff[NOW_W-1:0];
    end

    // Recoverable lateness: debt rounded up to whole periods (one period for zero debt), or half a period
    always_comb
    begin
        priority if (cfg.policy)
        begin
            limit_next = LIMIT_W'(period_reg >> 1);
        end
        else if (cfg.debt == '0)
        begin
            limit_next = LIMIT_W'(period_reg);
        end
        else if (div_rem == '0)
        begin
            limit_next = LIMIT_W'(cfg.debt);
        end
        else
        begin
            limit_next = LIMIT_W'(cfg.debt) - LIMIT_W'(div_rem) + LIMIT_W'(period_reg);
        end
    end

    assign carry = (late_reg[NOW_W-1:LIMIT_W] == '0) && (late_reg[LIMIT_W-1:0] <= limit_reg);

    // Pacing state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            nd_reg      <= '0;
            rem_reg     <= '0;
            misses_reg  <= '0;
            resyncs_reg <= '0;
        end
        else if (cfg_clear)
        begin
            started_reg <= 1'b0;
            nd_reg      <= '0;
            rem_reg     <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                started_reg <= 1'b1;
                nd_reg      <= now_reg;
            end
            if (cmd.add_period)
            begin
                nd_reg  <= nd_reg + {{(NOW_W-DIV_W){1'b0}}, div_quot};
                rem_reg <= div_rem[RATE_W-1:0];
            end
            if (cmd.compare && now_ge)
            begin
                misses_reg <= misses_reg + 1'b1;
            end
            if (cmd.resolve && !carry)
            begin
                resyncs_reg <= resyncs_reg + 1'b1;
                nd_reg      <= now_reg;
                rem_reg     <= '0;
            end
        end
    end

    // Working registers of the current word
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            now_reg    <= now_ns;
            period_reg <= '0;
            late_reg   <= '0;
            sleep_reg  <= '0;
            act_reg    <= ACT_DISABLED;
        end
        if (cmd.start)
        begin
            act_reg <= ACT_STARTED;
        end
        if (cmd.add_period)
        begin
            period_reg <= div_quot;
        end
        if (cmd.compare)
        begin
            miss_reg <= now_ge;
            if (now_ge)
            begin
                late_reg <= cmp_diff[NOW_W-1:0];
            end
            else
            begin
                sleep_reg <= sleep_next;
                act_reg   <= ACT_WAIT;
            end
        end
        if (cmd.set_limit)
        begin
            limit_reg <= limit_next;
        end
        if (cmd.resolve)
        begin
            act_reg <= carry ? ACT_CARRY : ACT_RESYNC;
        end
    end

    // Output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_act_reg      <= act_reg;
            out_deadline_reg <= (act_reg == ACT_DISABLED) ? '0 : nd_reg;
            out_sleep_reg    <= sleep_reg;
            out_late_reg     <= late_reg;
            out_period_reg   <= period_reg;
            out_miss_reg     <= misses_reg;
            out_resync_reg   <= resyncs_reg;
        end
    end

    // Status to the controller
    assign sts.enabled  = cfg.enable && (cfg.rate != '0);
    assign sts.started  = started_reg;
    assign sts.div_busy = div_busy;
    assign sts.miss     = miss_reg;
    assign sts.need_div = !cfg.policy && (cfg.debt != '0);
    assign sts.out_busy = out_valid_reg && !out_ready;

    assign out_valid      = out_valid_reg;
    assign action         = out_act_reg;
    assign deadline_ns    = out_deadline_reg;
    assign sleep_until_ns = out_sleep_reg;
    assign lateness_ns    = out_late_reg;
    assign period_ns      = out_period_reg;
    assign miss_count     = out_miss_reg;
    assign resync_count   = out_resync_reg;

    `FDP_ASSERT_IMP(a_load_slot_free, cmd.load_out, !out_valid_reg || out_ready, "result word overwritten")
    `FDP_ASSERT_IMP(a_wait_no_late, cmd.load_out && act_reg == ACT_WAIT, late_reg == '0, "wait word with lateness")

endmodule

[rtl/fdp_ctrl.sv]
// Controller of the frame deadline pacer: sequences one request word.
// Depends on fdp_pkg and the assertion macro header.
`include "frame_deadline_pacer_unit_macros.svh"

module fdp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output fdp_pkg::dp_cmd_t cmd,
    input  fdp_pkg::dp_sts_t sts
);
    import fdp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!sts.enabled || !sts.started)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DIV_RATE;
                end
            end
            ST_DIV_RATE:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_LIMIT;
            end
            ST_LIMIT:
            begin
                priority if (!sts.miss)
                begin
                    state_next = ST_EMIT;
                end
                else if (sts.need_div)
                begin
                    state_next = ST_DIV_DEBT;
                end
                else
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_DIV_DEBT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_CHECK:
            begin
                if (sts.enabled)
                begin
                    cmd.start  = !sts.started;
                    cmd.div_go = sts.started;
                end
            end
            ST_DIV_RATE:
            begin
                cmd.add_period = !sts.div_busy;
            end
            ST_CMP:
            begin
                cmd.compare = 1'b1;
            end
            ST_LIMIT:
            begin
                if (sts.miss)
                begin
                    cmd.div_go    = sts.need_div;
                    cmd.div_debt  = sts.need_div;
                    cmd.set_limit = !sts.need_div;
                end
            end
            ST_DIV_DEBT:
            begin
                cmd.set_limit = !sts.div_busy;
            end
            ST_RESOLVE:
            begin
                cmd.resolve = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.load_out = !sts.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `FDP_ASSERT_IMP(a_go_when_free, cmd.div_go, !sts.div_busy, "divider started while busy")

endmodule

[rtl/frame_deadline_pacer_unit.sv]
// Top level of the frame deadline pacer: registers, controller, datapath.
// Depends on fdp_pkg, fdp_regs, fdp_ctrl and fdp_dp.
//
//  Channel  Dir  Handshake                  Payload
//  request  in   in_valid / in_ready        now_ns
//  result   out  out_valid / out_ready      action, deadline_ns, sleep_until_ns,
//                                           lateness_ns, period_ns, miss_count,
//                                           resync_count
//  config   in   psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// Disabled and first requests skip the divider; wait and miss words pass through it once,
// and a miss under the debt policy with a nonzero limit passes through it twice.
// Both passes share the one 30-bit serial divider.
// Reset clears the pacing state and counters; there is no clearing pass.
// A new request is accepted while the previous result still waits in the output
// slot; a stalled result holds the controller only at its last step.
module frame_deadline_pacer_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [fdp_pkg::NOW_W-1:0]    now_ns,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fdp_pkg::ACT_W-1:0]    action,
    output logic [fdp_pkg::NOW_W-1:0]    deadline_ns,
    output logic [fdp_pkg::NOW_W-1:0]    sleep_until_ns,
    output logic [fdp_pkg::NOW_W-1:0]    lateness_ns,
    output logic [fdp_pkg::PERIOD_W-1:0] period_ns,
    output logic [fdp_pkg::CNT_W-1:0]    miss_count,
    output logic [fdp_pkg::CNT_W-1:0]    resync_count,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fdp_pkg::ADDR_W-1:0]   paddr,
    input  logic [fdp_pkg::DATA_W-1:0]   pwdata,
    output logic [fdp_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import fdp_pkg::*;

    cfg_t    cfg;
    logic    cfg_clear;
    dp_cmd_t cmd;
    dp_sts_t sts;

    fdp_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .cfg_clear (cfg_clear)
    );

    fdp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    fdp_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg            (cfg),
        .cfg_clear      (cfg_clear),
        .now_ns         (now_ns),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .action         (action),
        .deadline_ns    (deadline_ns),
        .sleep_until_ns (sleep_until_ns),
        .lateness_ns    (lateness_ns),
        .period_ns      (period_ns),
        .miss_count     (miss_count),
        .resync_count   (resync_count)
    );

endmodule

[test/tb_frame_deadline_pacer_unit.sv]
// Self-checking testbench for frame_deadline_pacer_unit: drives timestamped refresh
// requests, predicts every result word in a built-in pacer model and compares them.
// Depends on fdp_pkg and the frame_deadline_pacer_unit RTL.
module tb_frame_deadline_pacer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fdp_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1030;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [IDX_W-1:0] BAD_REG = 3'd5;    // first index past the register file
    localparam logic [NOW_W-1:0] NOW_MAX = {NOW_W{1'b1}};

    // Shape of the timestamp relative to the deadline the request will be checked against
    typedef enum int {
        T_EARLY, T_EDGE, T_ON_TIME, T_SLIGHT, T_HALF, T_HALF_PLUS,
        T_DEBT, T_LIMIT, T_LIMIT_PLUS, T_FAR, T_NOISE
    } now_mode_t;

    typedef struct packed {
        logic               started;
        logic [NOW_W-1:0]   deadline;
        logic [RATE_W-1:0]  rem;
        logic [CNT_W-1:0]   misses;
        logic [CNT_W-1:0]   resyncs;
        logic [CNT_W-1:0]   carried;
    } pace_state_t;

    typedef struct packed {
        action_t              act;
        logic [NOW_W-1:0]     deadline;
        logic [NOW_W-1:0]     sleep;
        logic [NOW_W-1:0]     late;
        logic [PERIOD_W-1:0]  period;
        logic [CNT_W-1:0]     misses;
        logic [CNT_W-1:0]     resyncs;
    } pace_result_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [NOW_W-1:0]      now_ns = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [ACT_W-1:0]      action;
    logic [NOW_W-1:0]      deadline_ns;
    logic [NOW_W-1:0]      sleep_until_ns;
    logic [NOW_W-1:0]      lateness_ns;
    logic [PERIOD_W-1:0]   period_ns;
    logic [CNT_W-1:0]      miss_count;
    logic [CNT_W-1:0]      resync_count;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    // Model copies: one advanced on acceptance, one ahead of it for planning timestamps
    cfg_t          cfg = '{enable: 1'b0, rate: RATE_RST, policy: 1'b0, debt: DEBT_RST,
                           spin: SPIN_RST};
    pace_state_t   pacer_state = '0;
    pace_state_t   lookahead = '0;

    logic [NOW_W-1:0] pending_now [$];
    pace_result_t     due_results [$];

    int  err_count = 0;
    int  sent_total = 0;
    int  accepted_total = 0;
    int  settings_count = 0;
    int  cycle_count = 0;
    int  act_seen [5] = '{default: 0};
    int  hold_left = 0;
    int  in_gap = 0;
    int  out_stall = 0;
    bit  in_idle_on = 1'b1;
    bit  out_idle_on = 1'b1;
    logic req_taken = 1'b0;
    logic res_taken = 1'b0;

    frame_deadline_pacer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .now_ns         (now_ns),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .action         (action),
        .deadline_ns    (deadline_ns),
        .sleep_until_ns (sleep_until_ns),
        .lateness_ns    (lateness_ns),
        .period_ns      (period_ns),
        .miss_count     (miss_count),
        .resync_count   (resync_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Pacer behavior for one request; updates the given state copy
    function automatic pace_result_t pace_request(inout pace_state_t st, input cfg_t c,
                                                  input logic [NOW_W-1:0] now);
        pace_result_t r;
        logic [63:0]  acc, per, periods, late, spin;
        logic         carry;
        r.act = ACT_DISABLED;
        r.deadline = '0;
        r.sleep = '0;
        r.late = '0;
        r.period = '0;
        if (!c.enable || c.rate == '0)
            r.act = ACT_DISABLED;
        else if (!st.started)
        begin
            st.started = 1'b1;
            st.deadline = now;
            r.act = ACT_STARTED;
            r.deadline = now;
        end
        else
        begin
            // fractional period: remainder carries into the next one
            acc = 64'(st.rem) + 64'(NS_PER_SEC);
            per = acc / 64'(c.rate);
            st.rem = RATE_W'(acc % 64'(c.rate));
            st.deadline = st.deadline + per[NOW_W-1:0];
            if (now >= st.deadline)
            begin
                late = 64'(now) - 64'(st.deadline);
                st.misses = st.misses + 1;
                if (!c.policy)
                begin
                    periods = (64'(c.debt) + per - 64'd1) / per;
                    if (periods == 64'd0)
                        periods = 64'd1;
                    carry = (late <= per * periods);
                end
                else
                    carry = (late <= per / 64'd2);
                if (carry)
                begin
                    st.carried = st.carried + 1;
                    r.act = ACT_CARRY;
                end
                else
                begin
                    st.resyncs = st.resyncs + 1;
                    st.deadline = now;
                    st.rem = '0;
                    r.act = ACT_RESYNC;
                end
                r.late = late[NOW_W-1:0];
            end
            else
            begin
                // sleep point saturates at zero when the spin window is larger
                spin = per / 64'd8;
                if (64'(c.spin) < spin)
                    spin = 64'(c.spin);
                r.sleep = (64'(st.deadline) >= spin) ? NOW_W'(64'(st.deadline) - spin) : '0;
                r.act = ACT_WAIT;
            end
            r.deadline = st.deadline;
            r.period = per[PERIOD_W-1:0];
        end
        r.misses = st.misses;
        r.resyncs = st.resyncs;
        return r;
    endfunction

    // Timestamp placed around the deadline the next request will be tested against
    function automatic logic [NOW_W-1:0] pick_now(now_mode_t m);
        logic [63:0] per, target, lim, periods, raw;
        raw = {$urandom, $urandom};
        if (!cfg.enable || cfg.rate == '0 || !lookahead.started || m == T_NOISE)
            return NOW_W'(raw >> $urandom_range(0, 40));
        per = (64'(lookahead.rem) + 64'(NS_PER_SEC)) / 64'(cfg.rate);
        target = 64'(lookahead.deadline) + per;
        if (cfg.policy)
            lim = per / 64'd2;
        else
        begin
            periods = (64'(cfg.debt) + per - 64'd1) / per;
            if (periods == 64'd0)
                periods = 64'd1;
            lim = per * periods;
        end
        case (m)
            T_EARLY:      target = target - 64'($urandom_range(1, per[31:0]));
            T_EDGE:       target = target - 64'd1;
            T_ON_TIME:    ;
            T_SLIGHT:     target = target + 64'($urandom_range(0, per[31:0] / 2));
            T_HALF:       target = target + per / 64'd2;
            T_HALF_PLUS:  target = target + per / 64'd2 + 64'd1;
            T_DEBT:       target = target + raw % (lim + 64'd1);
            T_LIMIT:      target = target + lim;
            T_LIMIT_PLUS: target = target + lim + 64'd1;
            default:      target = target + lim + 64'd1 + 64'(raw[40:0]);
        endcase
        return target[NOW_W-1:0];
    endfunction

    task automatic send_now(input logic [NOW_W-1:0] now);
        pending_now.push_back(now);
        void'(pace_request(lookahead, cfg, now));
        sent_total++;
    endtask

    // Wait until every queued request has been taken and answered
    task automatic drain();
        while (accepted_total != sent_total || due_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // any valid write restarts pacing; counters survive
        case (idx)
            REG_ENABLE: cfg.enable = data[0];
            REG_RATE:   cfg.rate = data[RATE_W-1:0];
            REG_POLICY: cfg.policy = data[0];
            REG_DEBT:   cfg.debt = data[DEBT_W-1:0];
            REG_SPIN:   cfg.spin = data[SPIN_W-1:0];
            default:    return;
        endcase
        pacer_state.started = 1'b0;
        pacer_state.deadline = '0;
        pacer_state.rem = '0;
        lookahead.started = 1'b0;
        lookahead.deadline = '0;
        lookahead.rem = '0;
    endtask

    task automatic apb_read(input logic [IDX_W-1:0] idx, output logic [DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        data = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write all five registers, sometimes with junk above the field, then read them back
    task automatic program_regs(input logic en, input logic [RATE_W-1:0] rate,
                                input logic pol, input logic [DEBT_W-1:0] debt,
                                input logic [SPIN_W-1:0] spin);
        logic [DATA_W-1:0] val [5];
        int                width [5];
        logic [DATA_W-1:0] mask, got;
        val[REG_ENABLE] = 32'(en);
        val[REG_RATE] = 32'(rate);
        val[REG_POLICY] = 32'(pol);
        val[REG_DEBT] = 32'(debt);
        val[REG_SPIN] = 32'(spin);
        width = '{1, RATE_W, 1, DEBT_W, SPIN_W};
        for (int i = 0; i < 5; i++)
        begin
            mask = (32'd1 << width[i]) - 32'd1;
            apb_write(IDX_W'(i),
                      val[i] | (($urandom_range(0, 3) == 0) ? ($urandom & ~mask) : 32'd0));
        end
        for (int i = 0; i < 5; i++)
        begin
            mask = (32'd1 << width[i]) - 32'd1;
            apb_read(IDX_W'(i), got);
            if (got !== (val[i] & mask))
            begin
                $error("prdata reg %0d: expected %0h, actual %0h", i, val[i] & mask, got);
                err_count++;
            end
        end
        settings_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endtask

    // Request side: acceptance and prediction at the rising edge
    always @(posedge clk)
    begin
        pace_result_t r;
        if (!rst_n)
            req_taken <= 1'b0;
        else
        begin
            req_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                r = pace_request(pacer_state, cfg, now_ns);
                due_results.push_back(r);
                accepted_total++;
            end
        end
    end

    // Request driver: next word after a random gap
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || req_taken)
        begin
            if (req_taken)
                in_gap = in_idle_on ? $urandom_range(0, 6) : 0;
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_now.size() != 0)
            begin
                now_ns <= pending_now.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Long receiver hold-off, counted down on its own
    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Result side ready: random stall after each word taken
    always @(negedge clk)
    begin
        if (!rst_n || hold_left > 0)
            out_ready <= 1'b0;
        else
        begin
            if (res_taken)
                out_stall = out_idle_on ? $urandom_range(0, 6) : 0;
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Result monitor: compare against the oldest prediction
    always @(posedge clk)
    begin
        pace_result_t want;
        if (!rst_n)
            res_taken <= 1'b0;
        else
        begin
            res_taken <= out_valid && out_ready;
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result word with no request outstanding");
                    err_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("action", 64'(want.act), 64'(action));
                    check_field("deadline_ns", 64'(want.deadline), 64'(deadline_ns));
                    check_field("sleep_until_ns", 64'(want.sleep), 64'(sleep_until_ns));
                    check_field("lateness_ns", 64'(want.late), 64'(lateness_ns));
                    check_field("period_ns", 64'(want.period), 64'(period_ns));
                    check_field("miss_count", 64'(want.misses), 64'(miss_count));
                    check_field("resync_count", 64'(want.resyncs), 64'(resync_count));
                    act_seen[want.act]++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int        r;
        int        phase;
        int        len;
        int        random_sent;
        logic      en, pol;
        logic [RATE_W-1:0] rate;
        logic [DEBT_W-1:0] debt;
        logic [SPIN_W-1:0] spin;
        now_mode_t mode;

        phase = 0;
        random_sent = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Out of reset pacing is off
        send_now('0);
        send_now(NOW_MAX);
        drain();

        // One-second period, zero debt (a one-period limit), widest spin window
        program_regs(1'b1, 16'd1, 1'b0, '0, {SPIN_W{1'b1}});
        send_now('0);
        send_now(63'd1);
        send_now(63'd2_000_000_000);     // on the deadline: zero lateness
        send_now(63'd5_000_000_001);     // beyond one period: resync
        send_now(63'd6_000_000_001);
        send_now(63'd8_000_000_001);     // exactly at the debt limit
        send_now(63'd9_000_000_002);     // one past it
        drain();

        // Write to an unmapped index must leave the running deadline alone
        apb_write(BAD_REG, 32'hFFFF_FFFF);
        send_now(pick_now(T_EARLY));
        drain();

        // Fastest rate, half-period policy, no spin window
        program_regs(1'b1, 16'hFFFF, 1'b1, {DEBT_W{1'b1}}, '0);
        send_now(63'd100);
        send_now(pick_now(T_EDGE));
        send_now(pick_now(T_HALF));
        send_now(pick_now(T_HALF_PLUS));
        send_now(pick_now(T_ON_TIME));
        drain();

        // Deadline wrapping past 2^63 and the sleep point saturating at zero
        program_regs(1'b1, 16'd1, 1'b0, 30'd1_000_000_000, 24'd10_000_000);
        send_now(NOW_MAX - 63'd999_999_994);
        send_now('0);
        send_now(NOW_MAX);
        send_now('0);
        drain();

        // Zero rate and cleared enable both idle the pacer
        program_regs(1'b1, '0, 1'b0, DEBT_RST, SPIN_RST);
        send_now(pick_now(T_NOISE));
        drain();
        program_regs(1'b0, RATE_RST, 1'b1, DEBT_RST, SPIN_RST);
        send_now(pick_now(T_NOISE));
        drain();

        // Random settings, each followed by a run of mostly well-placed timestamps
        while (random_sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 19);
            en = (r != 0);
            r = $urandom_range(0, 19);
            if (r == 0)
                rate = '0;
            else if (r == 1)
                rate = 16'd1;
            else if (r == 2)
                rate = 16'hFFFF;
            else if (r < 14)
                rate = RATE_W'($urandom_range(24, 240));
            else if (r < 17)
                rate = RATE_W'($urandom_range(1, 65535));
            else
                rate = RATE_W'($urandom_range(1000, 65535));
            pol = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 9);
            if (r == 0)
                debt = '0;
            else if (r == 1)
                debt = 30'd1;
            else if (r == 2)
                debt = 30'd1_000_000_000;
            else if (r == 3)
                debt = {DEBT_W{1'b1}};
            else
                debt = DEBT_W'($urandom_range(1, 1_000_000_000));
            r = $urandom_range(0, 9);
            if (r == 0)
                spin = '0;
            else if (r == 1)
                spin = {SPIN_W{1'b1}};
            else
                spin = SPIN_W'($urandom_range(0, 10_000_000));
            program_regs(en, rate, pol, debt, spin);

            in_idle_on = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            if (phase == 2)
            begin
                // sender keeps offering while results are held back
                in_idle_on = 1'b0;
                @(posedge clk);
                hold_left = HOLD_CYCLES;
            end

            len = $urandom_range(20, 70);
            for (int k = 0; k < len; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 38)
                    mode = T_EARLY;
                else if (r < 44)
                    mode = T_EDGE;
                else if (r < 49)
                    mode = T_ON_TIME;
                else if (r < 61)
                    mode = T_SLIGHT;
                else if (r < 65)
                    mode = T_HALF;
                else if (r < 69)
                    mode = T_HALF_PLUS;
                else if (r < 78)
                    mode = T_DEBT;
                else if (r < 82)
                    mode = T_LIMIT;
                else if (r < 86)
                    mode = T_LIMIT_PLUS;
                else if (r < 93)
                    mode = T_FAR;
                else
                    mode = T_NOISE;
                send_now(pick_now(mode));
                random_sent++;
            end
            drain();
            phase++;
        end

        repeat (40) @(posedge clk);
        $display("Sent %0d requests across %0d register settings, one %0d-cycle result stall.",
                 sent_total, settings_count, HOLD_CYCLES);
        $display("Actions: disabled %0d, started %0d, wait %0d, carry %0d, resync %0d",
                 act_seen[ACT_DISABLED], act_seen[ACT_STARTED], act_seen[ACT_WAIT],
                 act_seen[ACT_CARRY], act_seen[ACT_RESYNC]);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/fdp_pkg.sv
rtl/fdp_regs.sv
rtl/fdp_div.sv
rtl/fdp_dp.sv
rtl/fdp_ctrl.sv
rtl/frame_deadline_pacer_unit.sv
test/tb_frame_deadline_pacer_unit.sv
